>>> src/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// shared types and constants of the keypad matrix scanner
// ----------------------------------------------------------------------------
package kms_pkg;

    localparam int unsigned ACT_W  = 2;
    localparam int unsigned OFS_W  = 8;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned NCOL   = 5;
    localparam int unsigned NROW   = 5;
    localparam int unsigned CFG_IDX_W = 3;

    // item actions
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_ACK   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIVE_ROW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWR_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LVL_OFS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_OFS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_OFS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_OFS    = 3'd5;

    localparam logic [NCOL-1:0]   COLS_IDLE   = 5'h1f;
    localparam logic [NROW-1:0]   ROWS_FIVE   = 5'h1f;
    localparam logic [NROW-1:0]   ROWS_FOUR   = 5'h0f;
    localparam logic [2:0]        COL_PAD     = 3'b111;   // 0xe0 on column reads

    typedef logic [NCOL-1:0][NROW-1:0] t_keys;

    typedef struct packed {
        logic              five_row;
        logic [NCOL-1:0]   pwr_mask;
        logic [OFS_W-1:0]  lvl_ofs;
        logic [OFS_W-1:0]  col_ofs;
        logic [OFS_W-1:0]  mask_ofs;
        logic [OFS_W-1:0]  dir_ofs;
    } t_cfg;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [OFS_W-1:0]  offset;
        logic [BYTE_W-1:0] write_data;
        t_keys             keys;
        logic              power_line;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              irq;
    } t_result;

    typedef struct packed {
        logic pending;
        logic irq;
    } t_status;

endpackage

>>> src/kms_in_if.sv
// ----------------------------------------------------------------------------
// kms_in_if
// input word channel: action, bus access and key line snapshot
// ----------------------------------------------------------------------------
interface kms_in_if import kms_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [OFS_W-1:0]    offset;
    logic [BYTE_W-1:0]   write_data;
    logic [NROW-1:0]     keys_col0;
    logic [NROW-1:0]     keys_col1;
    logic [NROW-1:0]     keys_col2;
    logic [NROW-1:0]     keys_col3;
    logic [NROW-1:0]     keys_col4;
    logic                power_line;

    modport source (
        output valid, action, offset, write_data,
        output keys_col0, keys_col1, keys_col2, keys_col3, keys_col4, power_line,
        input  ready
    );
    modport sink (
        input  valid, action, offset, write_data,
        input  keys_col0, keys_col1, keys_col2, keys_col3, keys_col4, power_line,
        output ready
    );
endinterface

>>> src/kms_out_if.sv
// ----------------------------------------------------------------------------
// kms_out_if
// result word channel: read data and irq level
// ----------------------------------------------------------------------------
interface kms_out_if import kms_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   read_data;
    logic                irq;

    modport source (output valid, read_data, irq, input ready);
    modport sink   (input valid, read_data, irq, output ready);
endinterface

>>> src/kms_cfg_regs.sv
// ----------------------------------------------------------------------------
// kms_cfg_regs
// configuration registers behind the plain write port
// ----------------------------------------------------------------------------
module kms_cfg_regs import kms_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [BYTE_W-1:0]    i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_idx)
                CFG_FIVE_ROW: n_cfg.five_row = i_data[0];
                CFG_PWR_MASK: n_cfg.pwr_mask = i_data[NCOL-1:0];
                CFG_LVL_OFS:  n_cfg.lvl_ofs  = i_data;
                CFG_COL_OFS:  n_cfg.col_ofs  = i_data;
                CFG_MASK_OFS: n_cfg.mask_ofs = i_data;
                CFG_DIR_OFS:  n_cfg.dir_ofs  = i_data;
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.five_row <= 1'b1;
            r_cfg.pwr_mask <= 5'h01;
            r_cfg.lvl_ofs  <= 8'd0;
            r_cfg.col_ofs  <= 8'd1;
            r_cfg.mask_ofs <= 8'd2;
            r_cfg.dir_ofs  <= 8'd3;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/kms_sampler.sv
// ----------------------------------------------------------------------------
// kms_sampler
// column sampling of the key matrix and power key, latch term excluded
// ----------------------------------------------------------------------------
module kms_sampler import kms_pkg::*; (
    input  logic              i_five_row,
    input  logic [BYTE_W-1:0] i_row_level,
    input  logic [BYTE_W-1:0] i_row_dir,
    input  t_keys             i_keys,
    input  logic              i_power_line,
    input  logic [NCOL-1:0]   i_pwr_mask,
    output logic [NCOL-1:0]   o_cols
);

    logic [NROW-1:0] w_low;
    logic [NCOL-1:0] w_hit;

    // driven-low rows, only four count in four row mode
    assign w_low = i_row_dir[NROW-1:0] & ~i_row_level[NROW-1:0]
                 & (i_five_row ? ROWS_FIVE : ROWS_FOUR);

    always_comb begin
        for (int c = 0; c < NCOL; c++) begin
            if (i_five_row) begin
                w_hit[c] = |(w_low & ~i_keys[c]);
            end else begin
                // four row mode: row r reads key bit r+1
                w_hit[c] = |(w_low[NROW-2:0] & ~i_keys[c][NROW-1:1]);
            end
        end
    end

    assign o_cols = ~w_hit & (i_power_line ? COLS_IDLE : ~i_pwr_mask);

endmodule

>>> src/kms_core.sv
// ----------------------------------------------------------------------------
// kms_core
// bus registers, change detector and irq latch, one word per cycle while i_fire is high
// ----------------------------------------------------------------------------
module kms_core import kms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result,
    output t_status o_status
);

    logic [BYTE_W-1:0] r_lvl, r_dir, r_mask;
    logic [BYTE_W-1:0] n_lvl, n_dir, n_mask;
    logic [NCOL-1:0]   r_base, n_base;
    logic              r_pending, n_pending;
    logic              r_irq, n_irq;

    logic              w_hit_lvl, w_hit_dir, w_hit_mask, w_hit_col;
    logic              w_wr;
    logic [NCOL-1:0]   w_cols, w_cols_pend, w_changed;
    logic [BYTE_W-1:0] w_rd;

    assign w_hit_lvl  = (i_item.offset == i_cfg.lvl_ofs);
    assign w_hit_dir  = (i_item.offset == i_cfg.dir_ofs);
    assign w_hit_mask = (i_item.offset == i_cfg.mask_ofs);
    assign w_hit_col  = (i_item.offset == i_cfg.col_ofs);
    assign w_wr       = (i_item.action == ACT_WRITE);

    // writes land first, the sample below sees the new rows
    assign n_lvl  = (w_wr && w_hit_lvl)  ? i_item.write_data : r_lvl;
    assign n_dir  = (w_wr && w_hit_dir)  ? i_item.write_data : r_dir;
    assign n_mask = (w_wr && w_hit_mask) ? i_item.write_data : r_mask;

    kms_sampler u_sampler (
        .i_five_row   (i_cfg.five_row),
        .i_row_level  (n_lvl),
        .i_row_dir    (n_dir),
        .i_keys       (i_item.keys),
        .i_power_line (i_item.power_line),
        .i_pwr_mask   (i_cfg.pwr_mask),
        .o_cols       (w_cols)
    );

    assign w_cols_pend = r_pending ? (w_cols & ~i_cfg.pwr_mask) : w_cols;
    assign w_changed   = (r_base ^ w_cols_pend) & ~n_mask[NCOL-1:0];

    always_comb begin
        n_base    = r_base;
        n_pending = r_pending;
        n_irq     = r_irq;
        w_rd      = '0;
        case (i_item.action)
            ACT_READ: begin
                if (w_hit_col) begin
                    w_rd      = {COL_PAD, w_cols_pend};
                    n_pending = 1'b0;
                end else if (w_hit_lvl) begin
                    w_rd = r_lvl;
                end else if (w_hit_mask) begin
                    w_rd = r_mask;
                end else if (w_hit_dir) begin
                    w_rd = r_dir;
                end
            end
            ACT_WRITE, ACT_TICK: begin
                // unowned write offsets leave the detector alone
                if (i_item.action == ACT_TICK || w_hit_lvl || w_hit_mask || w_hit_dir) begin
                    n_base = w_cols_pend;
                    if (|w_changed) begin
                        n_irq = 1'b1;
                    end
                end
            end
            ACT_ACK: begin
                n_irq = 1'b0;
                if (r_pending) begin
                    n_pending = 1'b0;
                    n_base    = w_cols;
                end
            end
            default: begin
                n_irq = r_irq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl     <= '0;
            r_dir     <= '0;
            r_mask    <= '0;
            r_base    <= COLS_IDLE;
            r_pending <= 1'b1;
            r_irq     <= 1'b0;
        end else if (i_fire) begin
            r_lvl     <= n_lvl;
            r_dir     <= n_dir;
            r_mask    <= n_mask;
            r_base    <= n_base;
            r_pending <= n_pending;
            r_irq     <= n_irq;
        end
    end

    assign o_result.read_data = w_rd;
    assign o_result.irq       = n_irq;
    assign o_status.pending   = r_pending;
    assign o_status.irq       = r_irq;

endmodule

>>> src/keypad_matrix_gpio_scanner.sv
// ----------------------------------------------------------------------------
// keypad_matrix_gpio_scanner
// keypad gpio controller with row drive, column read port and change irq
// ----------------------------------------------------------------------------
// One word is taken per clock and every word gives one result word. A word
// enters an input register, is worked in a single pass through the bus
// register and column sampling logic once the output register has room,
// and its result is valid from that output register, one word per cycle
// sustained while the result side keeps taking words. A held result stalls
// the input side only when both registers are full. Actions are bus read,
// bus write, sample tick and irq acknowledge. Configuration (row mode, power
// column mask and the four bus offsets) must be written through the plain
// write port only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module keypad_matrix_gpio_scanner import kms_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    // word channels
    kms_in_if.sink               i_item,
    kms_out_if.source            o_result
);

    t_cfg    w_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result w_res;
    t_status w_status;
    logic    w_out_free;
    logic    w_fire;
    logic    w_take;

    // output register can load when empty or being drained
    assign w_out_free = !r_out_valid || o_result.ready;
    // the registered word is worked when its result has a place to go
    assign w_fire     = r_in_valid && w_out_free;
    assign i_item.ready = !r_in_valid || w_fire;
    assign w_take     = i_item.valid && i_item.ready;

    kms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.action     <= i_item.action;
            r_item.offset     <= i_item.offset;
            r_item.write_data <= i_item.write_data;
            r_item.keys       <= {i_item.keys_col4, i_item.keys_col3, i_item.keys_col2,
                                  i_item.keys_col1, i_item.keys_col0};
            r_item.power_line <= i_item.power_line;
        end
    end

    kms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_res),
        .o_status (w_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.read_data = r_out.read_data;
    assign o_result.irq       = r_out.irq;

`ifndef NO_ASSERTIONS
    // cold-start latch is one-shot until reset
    a_pending_one_shot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_status.pending |=> !w_status.pending)
        else $error("cold-start latch re-armed");

    // result irq matches the latched irq after the word
    a_irq_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_out.irq == w_status.irq))
        else $error("result irq differs from latch");

    // acknowledge always leaves irq clear
    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_item.action == ACT_ACK) |=> !w_status.irq)
        else $error("irq set after acknowledge");

    // only bus reads return data
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_item.action != ACT_READ) |=> (r_out.read_data == '0))
        else $error("read data on non-read word");
`endif

endmodule

>>> tb/keypad_matrix_gpio_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_matrix_gpio_scanner_tb
// self-checking bench: directed cold-start, masking and offset cases, then
// random bus traffic and ticks under several register settings, with random
// sender gaps and receiver stalls and an in-order predictor in a class
// ----------------------------------------------------------------------------
module keypad_matrix_gpio_scanner_tb;
    import kms_pkg::*;

    localparam int    QUIET_LIMIT  = 2000;   // cycles with no word moving
    localparam int    PHASE_WORDS  = 218;    // random words per register setting
    localparam int    NUM_SETTINGS = 7;
    localparam t_keys KEYS_UP      = '1;     // every key released

    // register values right after reset
    localparam t_cfg CFG_DEFAULT = '{five_row: 1'b1, pwr_mask: 5'h01, lvl_ofs: 8'h00,
                                     col_ofs: 8'h01, mask_ofs: 8'h02, dir_ofs: 8'h03};

    // ------------------------------------------------------------------------
    // predictor and store of pending result words
    // ------------------------------------------------------------------------
    class scan_checker;
        t_cfg              cfg;
        logic [BYTE_W-1:0] lvl_reg;
        logic [BYTE_W-1:0] dir_reg;
        logic [BYTE_W-1:0] irqmask_reg;
        logic [NCOL-1:0]   col_base;
        logic              cold_latch;
        logic              irq_flag;
        t_result           due_results[$];
        int                words_in;
        int                words_out;
        int                errors;

        function new();
            cfg         = CFG_DEFAULT;
            lvl_reg     = '0;
            dir_reg     = '0;
            irqmask_reg = '0;
            col_base    = COLS_IDLE;
            cold_latch  = 1'b1;
            irq_flag    = 1'b0;
            words_in    = 0;
            words_out   = 0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
            case (idx)
                CFG_FIVE_ROW: cfg.five_row = data[0];
                CFG_PWR_MASK: cfg.pwr_mask = data[NCOL-1:0];
                CFG_LVL_OFS:  cfg.lvl_ofs  = data;
                CFG_COL_OFS:  cfg.col_ofs  = data;
                CFG_MASK_OFS: cfg.mask_ofs = data;
                CFG_DIR_OFS:  cfg.dir_ofs  = data;
                default: ;
            endcase
        endfunction

        // column lines as the port would see them, active low
        function logic [NCOL-1:0] column_levels(t_item w);
            logic [NROW-1:0] driven;
            logic [NCOL-1:0] cols;
            int              nrows;
            cols   = COLS_IDLE;
            driven = dir_reg[NROW-1:0] & ~lvl_reg[NROW-1:0] &
                     (cfg.five_row ? ROWS_FIVE : ROWS_FOUR);
            nrows  = cfg.five_row ? 5 : 4;
            for (int c = 0; c < NCOL; c++)
                for (int r = 0; r < nrows; r++)
                    if (driven[r] && !w.keys[c][cfg.five_row ? r : r + 1])
                        cols[c] = 1'b0;
            if (!w.power_line || cold_latch)
                cols &= ~cfg.pwr_mask;
            return cols;
        endfunction

        function void rescan(t_item w);
            logic [NCOL-1:0] cols;
            cols = column_levels(w);
            if (|((col_base ^ cols) & ~irqmask_reg[NCOL-1:0]))
                irq_flag = 1'b1;
            col_base = cols;
        endfunction

        function void take_word(t_item w);
            t_result want;
            logic    hit;
            want.read_data = '0;
            hit = 1'b0;
            words_in++;
            case (w.action)
                ACT_READ: begin
                    if (w.offset == cfg.col_ofs) begin
                        want.read_data = {COL_PAD, column_levels(w)};
                        cold_latch = 1'b0;
                    end else if (w.offset == cfg.lvl_ofs) begin
                        want.read_data = lvl_reg;
                    end else if (w.offset == cfg.mask_ofs) begin
                        want.read_data = irqmask_reg;
                    end else if (w.offset == cfg.dir_ofs) begin
                        want.read_data = dir_reg;
                    end
                end
                ACT_WRITE: begin
                    if (w.offset == cfg.lvl_ofs) begin
                        lvl_reg = w.write_data;
                        hit = 1'b1;
                    end
                    if (w.offset == cfg.mask_ofs) begin
                        irqmask_reg = w.write_data;
                        hit = 1'b1;
                    end
                    if (w.offset == cfg.dir_ofs) begin
                        dir_reg = w.write_data;
                        hit = 1'b1;
                    end
                    if (hit)
                        rescan(w);
                end
                ACT_TICK: rescan(w);
                default: begin
                    irq_flag = 1'b0;
                    if (cold_latch) begin
                        cold_latch = 1'b0;
                        col_base = column_levels(w);
                    end
                end
            endcase
            want.irq = irq_flag;
            due_results.push_back(want);
        endfunction

        function void check_word(t_result got);
            t_result want;
            words_out++;
            if (due_results.size() == 0) begin
                $error("result word with nothing pending: read_data %02h irq %0b",
                       got.read_data, got.irq);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %02h, actual %02h", want.read_data, got.read_data);
                errors++;
            end
            if (got.irq !== want.irq) begin
                $error("irq: expected %0b, actual %0b", want.irq, got.irq);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, block under test
    // ------------------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [BYTE_W-1:0] cfg_data;

    kms_in_if  word_in ();
    kms_out_if word_out ();

    scan_checker scan_chk = new();

    int quiet_cycles = 0;
    int sink_mode    = 0;
    int seg_left     = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    keypad_matrix_gpio_scanner DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (word_in),
        .o_result   (word_out)
    );

    // ------------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_item   seen;
        t_result got;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            // an input word is predicted the moment it is taken
            if (word_in.valid && word_in.ready) begin
                seen.action     = word_in.action;
                seen.offset     = word_in.offset;
                seen.write_data = word_in.write_data;
                seen.keys       = {word_in.keys_col4, word_in.keys_col3, word_in.keys_col2,
                                   word_in.keys_col1, word_in.keys_col0};
                seen.power_line = word_in.power_line;
                scan_chk.take_word(seen);
            end
            // a result word is matched against the oldest prediction
            if (word_out.valid && word_out.ready) begin
                got.read_data = word_out.read_data;
                got.irq       = word_out.irq;
                scan_chk.check_word(got);
            end
            if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog: the run is stuck if no word moves for too long
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $error("no word moved for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern changes every segment
    //   0 always ready, 1 coin flip, 2 periodic, 3 mostly stalled
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (seg_left == 0) begin
            seg_left  <= $urandom_range(16, 160);
            sink_mode <= $urandom_range(0, 3);
        end else begin
            seg_left <= seg_left - 1;
        end
        case (sink_mode)
            0:       word_out.ready <= 1'b1;
            1:       word_out.ready <= 1'($urandom_range(0, 1));
            2:       word_out.ready <= (seg_left % 3) != 0;
            default: word_out.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_item make_word(logic [ACT_W-1:0] action, logic [OFS_W-1:0] offset,
                                        logic [BYTE_W-1:0] data, t_keys keys, logic pwr);
        t_item w;
        w.action     = action;
        w.offset     = offset;
        w.write_data = data;
        w.keys       = keys;
        w.power_line = pwr;
        return w;
    endfunction

    // one register write per clock; the predictor follows at once since
    // nothing is in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        scan_chk.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // drain, program a register setting, then send the leading words and
    // a random tail in bursts with random gaps
    task automatic run_phase(t_cfg c, int count, t_item lead[$]);
        t_item            w;
        logic [OFS_W-1:0] owned[4];
        int               burst;
        int               gap;
        int               roll;
        word_in.valid <= 1'b0;
        while (scan_chk.due_results.size() != 0)
            @(negedge i_clk);
        write_reg(CFG_FIVE_ROW, BYTE_W'(c.five_row));
        write_reg(CFG_PWR_MASK, BYTE_W'(c.pwr_mask));
        write_reg(CFG_LVL_OFS,  c.lvl_ofs);
        write_reg(CFG_COL_OFS,  c.col_ofs);
        write_reg(CFG_MASK_OFS, c.mask_ofs);
        write_reg(CFG_DIR_OFS,  c.dir_ofs);
        cfg_we <= 1'b0;

        // random tail: mostly accesses to owned offsets, sparse key presses
        owned = '{c.lvl_ofs, c.col_ofs, c.mask_ofs, c.dir_ofs};
        repeat (count) begin
            roll = $urandom_range(0, 99);
            w.action = (roll < 30) ? ACT_READ :
                       (roll < 60) ? ACT_WRITE :
                       (roll < 85) ? ACT_TICK : ACT_ACK;
            w.offset = ($urandom_range(0, 4) != 0) ? owned[$urandom_range(0, 3)]
                                                   : OFS_W'($urandom_range(0, 255));
            w.write_data = BYTE_W'($urandom_range(0, 255));
            roll = $urandom_range(0, 9);
            w.keys = (roll < 7) ? KEYS_UP : t_keys'($urandom);
            if (roll >= 4 && roll < 7)
                w.keys[$urandom_range(0, 4)][$urandom_range(0, 4)] = 1'b0;
            w.power_line = ($urandom_range(0, 4) != 0);
            lead.push_back(w);
        end

        burst = 0;
        foreach (lead[i]) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    word_in.valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst--;
            word_in.valid      <= 1'b1;
            word_in.action     <= lead[i].action;
            word_in.offset     <= lead[i].offset;
            word_in.write_data <= lead[i].write_data;
            word_in.keys_col0  <= lead[i].keys[0];
            word_in.keys_col1  <= lead[i].keys[1];
            word_in.keys_col2  <= lead[i].keys[2];
            word_in.keys_col3  <= lead[i].keys[3];
            word_in.keys_col4  <= lead[i].keys[4];
            word_in.power_line <= lead[i].power_line;
            @(posedge i_clk);
            while (!word_in.ready)
                @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_item lead[$];
        t_cfg  plan[NUM_SETTINGS];
        int    lo_ofs;

        // every input known from time zero
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_FIVE_ROW;
        cfg_data           = '0;
        word_in.valid      = 1'b0;
        word_in.action     = ACT_READ;
        word_in.offset     = '0;
        word_in.write_data = '0;
        word_in.keys_col0  = '1;
        word_in.keys_col1  = '1;
        word_in.keys_col2  = '1;
        word_in.keys_col3  = '1;
        word_in.keys_col4  = '1;
        word_in.power_line = 1'b1;
        word_out.ready     = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register settings: reset values, extremes, fully and partly shared
        // offsets, then two random ones (the last with heavy offset overlap)
        plan[0] = CFG_DEFAULT;
        plan[1] = '{1'b0, 5'h1f, 8'hff, 8'h00, 8'h80, 8'h07};
        plan[2] = '{1'b1, 5'h00, 8'h55, 8'h55, 8'h55, 8'h55};
        plan[3] = '{1'b0, 5'h15, 8'h40, 8'h41, 8'h40, 8'h40};
        plan[4] = '{1'b1, 5'h1f, 8'h00, 8'hff, 8'hfe, 8'hfd};
        for (int p = 5; p < NUM_SETTINGS; p++) begin
            lo_ofs = (p == 5) ? 255 : 3;
            plan[p].five_row = 1'($urandom_range(0, 1));
            plan[p].pwr_mask = NCOL'($urandom_range(0, 31));
            plan[p].lvl_ofs  = OFS_W'($urandom_range(0, lo_ofs));
            plan[p].col_ofs  = OFS_W'($urandom_range(0, lo_ofs));
            plan[p].mask_ofs = OFS_W'($urandom_range(0, lo_ofs));
            plan[p].dir_ofs  = OFS_W'($urandom_range(0, lo_ofs));
        end

        // directed words under the reset setting
        // the cold-start latch pulls column 0 low, so the first tick raises irq
        lead.push_back(make_word(ACT_TICK, 8'h00, 8'h00, KEYS_UP, 1'b1));
        // the latch is consumed once: either by an acknowledge, which
        // re-baselines without it, or by a column read, which still sees it
        if ($urandom_range(0, 1))
            lead.push_back(make_word(ACT_ACK, 8'h00, 8'h00, KEYS_UP, 1'b1));
        else
            lead.push_back(make_word(ACT_READ, CFG_DEFAULT.col_ofs, 8'h00, KEYS_UP, 1'b1));
        // acknowledge with the latch already gone
        lead.push_back(make_word(ACT_ACK, 8'h00, 8'h00, KEYS_UP, 1'b1));
        // drive every row low
        lead.push_back(make_word(ACT_WRITE, CFG_DEFAULT.dir_ofs, 8'hff, KEYS_UP, 1'b1));
        lead.push_back(make_word(ACT_WRITE, CFG_DEFAULT.lvl_ofs, 8'h00, KEYS_UP, 1'b1));
        // all keys pressed: column read, then a change seen by a tick
        lead.push_back(make_word(ACT_READ, CFG_DEFAULT.col_ofs, 8'h00, t_keys'('0), 1'b1));
        lead.push_back(make_word(ACT_TICK, 8'h00, 8'h00, t_keys'('0), 1'b1));
        lead.push_back(make_word(ACT_ACK, 8'h00, 8'h00, t_keys'('0), 1'b1));
        // mask every column: release all keys, baseline moves but no irq
        lead.push_back(make_word(ACT_WRITE, CFG_DEFAULT.mask_ofs, 8'hff, t_keys'('0), 1'b1));
        lead.push_back(make_word(ACT_TICK, 8'h00, 8'h00, KEYS_UP, 1'b1));
        lead.push_back(make_word(ACT_READ, CFG_DEFAULT.mask_ofs, 8'h00, KEYS_UP, 1'b1));
        lead.push_back(make_word(ACT_READ, CFG_DEFAULT.lvl_ofs, 8'h00, KEYS_UP, 1'b1));
        lead.push_back(make_word(ACT_READ, CFG_DEFAULT.dir_ofs, 8'h00, KEYS_UP, 1'b1));
        // unowned offset: read gives zero, write is dropped
        lead.push_back(make_word(ACT_READ, 8'h80, 8'h00, KEYS_UP, 1'b1));
        lead.push_back(make_word(ACT_WRITE, 8'h80, 8'haa, t_keys'('0), 1'b0));
        // write to the column port has no effect
        lead.push_back(make_word(ACT_WRITE, CFG_DEFAULT.col_ofs, 8'h5a, t_keys'('0), 1'b0));
        // unmask, then the power key alone
        lead.push_back(make_word(ACT_WRITE, CFG_DEFAULT.mask_ofs, 8'h00, KEYS_UP, 1'b1));
        lead.push_back(make_word(ACT_TICK, 8'h00, 8'h00, KEYS_UP, 1'b0));
        lead.push_back(make_word(ACT_ACK, 8'h00, 8'h00, KEYS_UP, 1'b0));
        // single key at column 3, row 4 (bit 19 of the key snapshot)
        lead.push_back(make_word(ACT_READ, CFG_DEFAULT.col_ofs, 8'h00,
                                 t_keys'(~(25'h1 << 19)), 1'b1));
        // rows released high: pressed keys no longer reach the columns
        lead.push_back(make_word(ACT_WRITE, CFG_DEFAULT.lvl_ofs, 8'hff, t_keys'('0), 1'b1));
        lead.push_back(make_word(ACT_TICK, 8'h00, 8'h00, t_keys'('0), 1'b1));
        lead.push_back(make_word(ACT_WRITE, CFG_DEFAULT.dir_ofs, 8'h00, t_keys'('0), 1'b1));
        lead.push_back(make_word(ACT_WRITE, CFG_DEFAULT.lvl_ofs, 8'h55, KEYS_UP, 1'b1));
        lead.push_back(make_word(ACT_READ, 8'hff, 8'h00, KEYS_UP, 1'b1));

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            run_phase(plan[p], PHASE_WORDS, lead);
            lead.delete();
        end

        // let the last results drain, then a few cycles for stray words
        word_in.valid <= 1'b0;
        while (scan_chk.due_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("run covered %0d input words and %0d result words over %0d register settings",
                 scan_chk.words_in, scan_chk.words_out, NUM_SETTINGS);
        $display("including cold start, shared offsets, masked columns and four-row mode");
        if (scan_chk.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
